### rtl/i2cee_pkg.sv
// ----------------------------------------------------------------------------
// I2C EEPROM sequencer package
// Shared opcodes, bus action codes, result and run types, reset values.
// ----------------------------------------------------------------------------
package i2cee_pkg;

    localparam int DATA_W      = 8;
    localparam int ADDR_W      = 16;
    localparam int LEN_W       = 16;
    localparam int RUN_MAX     = 4;
    localparam int RUN_IDX_W   = $clog2(RUN_MAX);
    localparam int RUN_CNT_W   = $clog2(RUN_MAX + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic [DATA_W-1:0] DEVICE_CODE_RST = 8'hA0;
    localparam logic [DATA_W-1:0] HIGH_BLOCK_RST  = 8'h08;
    localparam logic [DATA_W-1:0] LOW_BLOCK_RST   = 8'h00;
    localparam logic [DATA_W-1:0] CTL_WRITE_MASK  = 8'hFE;
    localparam logic [DATA_W-1:0] CTL_READ_BIT    = 8'h01;

    typedef enum logic [1:0] {
        OP_WRITE_CMD = 2'd0,
        OP_READ_CMD  = 2'd1,
        OP_HOST_DATA = 2'd2,
        OP_BUS_RESP  = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEVICE_CODE = 2'd0,
        CFG_HIGH_BLOCK  = 2'd1,
        CFG_LOW_BLOCK   = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ACT_START   = 4'd0,
        ACT_RESTART = 4'd1,
        ACT_STOP    = 4'd2,
        ACT_WRITE   = 4'd3,
        ACT_READ    = 4'd4,
        ACT_ACK     = 4'd5,
        ACT_NACK    = 4'd6,
        ACT_TOHOST  = 4'd7,
        ACT_DONE    = 4'd8
    } t_action;

    typedef struct packed {
        t_action             action;
        logic [DATA_W-1:0]   byte_value;
        logic                success;
    } t_res;

    typedef struct packed {
        logic [RUN_CNT_W-1:0]   count;
        t_res [RUN_MAX-1:0]     res;
    } t_run;

endpackage

### rtl/i2cee_front.sv
// ----------------------------------------------------------------------------
// I2C EEPROM sequencer front end
// Accepts commands, host data and bus responses, steps the transaction
// phase and builds the run of bus primitives caused by each item.
// ----------------------------------------------------------------------------
module i2cee_front #(
    parameter int PAGE_BYTES = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_q_full,
    input  logic [1:0]                        i_opcode,
    input  logic [i2cee_pkg::ADDR_W-1:0]      i_address,
    input  logic                              i_block_high,
    input  logic [i2cee_pkg::LEN_W-1:0]       i_length,
    input  logic                              i_poll_after_write,
    input  logic [i2cee_pkg::DATA_W-1:0]      i_data_byte,
    input  logic                              i_bus_acked,
    input  logic [i2cee_pkg::DATA_W-1:0]      i_bus_read_byte,
    input  logic                              i_bus_read_error,
    input  logic                              i_cfg_wr_en,
    input  logic [i2cee_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [i2cee_pkg::DATA_W-1:0]      i_cfg_data,
    output logic                              o_push,
    output i2cee_pkg::t_run                   o_run
);

    localparam int OFF_W = $clog2(PAGE_BYTES);

    typedef logic [OFF_W-1:0] t_mod_tab [256];

    function automatic t_mod_tab f_mod_tab(input int shift);
        t_mod_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = OFF_W'(((i << shift) % PAGE_BYTES));
        end
        return tab;
    endfunction

    localparam t_mod_tab LO_TAB = f_mod_tab(0);
    localparam t_mod_tab HI_TAB = f_mod_tab(8);

    typedef enum logic [3:0] {
        PH_IDLE, PH_W_CTL, PH_W_AH, PH_W_AL, PH_W_NEED, PH_W_DATA, PH_W_POLL,
        PH_R_CTL, PH_R_AH, PH_R_AL, PH_R_CTLRD, PH_R_READ
    } t_phase;

    function automatic i2cee_pkg::t_run f_put(
        input i2cee_pkg::t_run                run,
        input i2cee_pkg::t_action             act,
        input logic [i2cee_pkg::DATA_W-1:0]   val,
        input logic                           ok
    );
        i2cee_pkg::t_run r;
        r = run;
        r.res[r.count[i2cee_pkg::RUN_IDX_W-1:0]].action     = act;
        r.res[r.count[i2cee_pkg::RUN_IDX_W-1:0]].byte_value = val;
        r.res[r.count[i2cee_pkg::RUN_IDX_W-1:0]].success    = ok;
        r.count = r.count + 1'b1;
        return r;
    endfunction

    t_phase                          r_phase, n_phase;
    logic [i2cee_pkg::DATA_W-1:0]    r_control_byte, n_control_byte;
    logic [i2cee_pkg::ADDR_W-1:0]    r_saved_address, n_saved_address;
    logic [i2cee_pkg::LEN_W-1:0]     r_target_count, n_target_count;
    logic [i2cee_pkg::LEN_W-1:0]     r_done_count, n_done_count;
    logic                            r_poll_enabled, n_poll_enabled;
    logic [i2cee_pkg::DATA_W-1:0]    r_device_code;
    logic [i2cee_pkg::DATA_W-1:0]    r_high_block_bits;
    logic [i2cee_pkg::DATA_W-1:0]    r_low_block_bits;

    logic                            accept;
    logic [OFF_W:0]                  off_sum;
    logic [OFF_W:0]                  off_red;
    logic [OFF_W-1:0]                page_off;
    logic [i2cee_pkg::LEN_W-1:0]     len_cap;
    logic [i2cee_pkg::LEN_W-1:0]     room;
    logic [i2cee_pkg::LEN_W-1:0]     len_wr;
    logic [i2cee_pkg::LEN_W-1:0]     len_rd;
    logic [i2cee_pkg::LEN_W:0]       done_inc;
    logic [i2cee_pkg::DATA_W-1:0]    ctl_new;
    logic [i2cee_pkg::DATA_W-1:0]    ctl_wr;
    i2cee_pkg::t_run                 run;

    assign accept   = i_valid && !i_q_full;
    assign off_sum  = {1'b0, HI_TAB[i_address[15:8]]} + {1'b0, LO_TAB[i_address[7:0]]};
    assign off_red  = (off_sum >= (OFF_W+1)'(PAGE_BYTES)) ?
                      off_sum - (OFF_W+1)'(PAGE_BYTES) : off_sum;
    assign page_off = off_red[OFF_W-1:0];
    assign len_cap  = (i_length > i2cee_pkg::LEN_W'(PAGE_BYTES)) ?
                      i2cee_pkg::LEN_W'(PAGE_BYTES) : i_length;
    assign room     = i2cee_pkg::LEN_W'(PAGE_BYTES) - i2cee_pkg::LEN_W'(page_off);
    assign len_wr   = (len_cap > room) ? room : len_cap;
    assign len_rd   = (i_length == '0) ? i2cee_pkg::LEN_W'(1) : i_length;
    assign done_inc = {1'b0, r_done_count} + 1'b1;
    assign ctl_new  = r_device_code | (i_block_high ? r_high_block_bits : r_low_block_bits);
    assign ctl_wr   = r_control_byte & i2cee_pkg::CTL_WRITE_MASK;

    always_comb begin
        n_phase         = r_phase;
        n_control_byte  = r_control_byte;
        n_saved_address = r_saved_address;
        n_target_count  = r_target_count;
        n_done_count    = r_done_count;
        n_poll_enabled  = r_poll_enabled;
        run             = '0;
        case (i2cee_pkg::t_opcode'(i_opcode))
            i2cee_pkg::OP_WRITE_CMD, i2cee_pkg::OP_READ_CMD: begin
                if (r_phase == PH_IDLE) begin
                    n_control_byte  = ctl_new;
                    n_saved_address = i_address;
                    n_done_count    = '0;
                    if (i2cee_pkg::t_opcode'(i_opcode) == i2cee_pkg::OP_READ_CMD) begin
                        n_target_count = len_rd;
                        n_poll_enabled = 1'b0;
                        n_phase        = PH_R_CTL;
                    end else begin
                        n_target_count = len_wr;
                        n_poll_enabled = i_poll_after_write;
                        n_phase        = PH_W_CTL;
                    end
                    run = f_put(run, i2cee_pkg::ACT_START, '0, 1'b0);
                    run = f_put(run, i2cee_pkg::ACT_WRITE,
                                ctl_new & i2cee_pkg::CTL_WRITE_MASK, 1'b0);
                end
            end
            i2cee_pkg::OP_HOST_DATA: begin
                if (r_phase == PH_W_NEED) begin
                    run     = f_put(run, i2cee_pkg::ACT_WRITE, i_data_byte, 1'b0);
                    n_phase = PH_W_DATA;
                end
            end
            default: begin
                case (r_phase)
                    PH_R_READ: begin
                        if (i_bus_read_error) begin
                            run     = f_put(run, i2cee_pkg::ACT_DONE, '0, 1'b0);
                            n_phase = PH_IDLE;
                        end else begin
                            run = f_put(run, i2cee_pkg::ACT_TOHOST, i_bus_read_byte, 1'b0);
                            n_done_count = done_inc[i2cee_pkg::LEN_W-1:0];
                            if (done_inc < {1'b0, r_target_count}) begin
                                run = f_put(run, i2cee_pkg::ACT_ACK, '0, 1'b0);
                                run = f_put(run, i2cee_pkg::ACT_READ, '0, 1'b0);
                            end else begin
                                run     = f_put(run, i2cee_pkg::ACT_NACK, '0, 1'b0);
                                run     = f_put(run, i2cee_pkg::ACT_STOP, '0, 1'b0);
                                run     = f_put(run, i2cee_pkg::ACT_DONE, '0, 1'b1);
                                n_phase = PH_IDLE;
                            end
                        end
                    end
                    PH_W_POLL: begin
                        if (i_bus_acked) begin
                            run     = f_put(run, i2cee_pkg::ACT_DONE, '0, 1'b1);
                            n_phase = PH_IDLE;
                        end else begin
                            run = f_put(run, i2cee_pkg::ACT_START, '0, 1'b0);
                            run = f_put(run, i2cee_pkg::ACT_WRITE, ctl_wr, 1'b0);
                        end
                    end
                    PH_W_CTL, PH_R_CTL, PH_W_AH, PH_R_AH, PH_W_AL, PH_W_DATA,
                    PH_R_AL, PH_R_CTLRD: begin
                        if (!i_bus_acked) begin
                            run     = f_put(run, i2cee_pkg::ACT_DONE, '0, 1'b0);
                            n_phase = PH_IDLE;
                        end else if (r_phase == PH_W_CTL || r_phase == PH_R_CTL) begin
                            run = f_put(run, i2cee_pkg::ACT_WRITE,
                                        r_saved_address[15:8], 1'b0);
                            n_phase = (r_phase == PH_W_CTL) ? PH_W_AH : PH_R_AH;
                        end else if (r_phase == PH_W_AH || r_phase == PH_R_AH) begin
                            run = f_put(run, i2cee_pkg::ACT_WRITE,
                                        r_saved_address[7:0], 1'b0);
                            n_phase = (r_phase == PH_W_AH) ? PH_W_AL : PH_R_AL;
                        end else if (r_phase == PH_R_AL) begin
                            run     = f_put(run, i2cee_pkg::ACT_RESTART, '0, 1'b0);
                            run     = f_put(run, i2cee_pkg::ACT_WRITE,
                                            r_control_byte | i2cee_pkg::CTL_READ_BIT, 1'b0);
                            n_phase = PH_R_CTLRD;
                        end else if (r_phase == PH_R_CTLRD) begin
                            run     = f_put(run, i2cee_pkg::ACT_READ, '0, 1'b0);
                            n_phase = PH_R_READ;
                        end else begin
                            if (r_phase == PH_W_DATA) begin
                                n_done_count = done_inc[i2cee_pkg::LEN_W-1:0];
                            end
                            if ((r_phase == PH_W_AL && r_target_count == '0) ||
                                (r_phase == PH_W_DATA &&
                                 done_inc >= {1'b0, r_target_count})) begin
                                run = f_put(run, i2cee_pkg::ACT_STOP, '0, 1'b0);
                                if (r_poll_enabled) begin
                                    run     = f_put(run, i2cee_pkg::ACT_START, '0, 1'b0);
                                    run     = f_put(run, i2cee_pkg::ACT_WRITE, ctl_wr, 1'b0);
                                    n_phase = PH_W_POLL;
                                end else begin
                                    run     = f_put(run, i2cee_pkg::ACT_DONE, '0, 1'b1);
                                    n_phase = PH_IDLE;
                                end
                            end else begin
                                n_phase = PH_W_NEED;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_IDLE;
            r_control_byte    <= '0;
            r_saved_address   <= '0;
            r_target_count    <= '0;
            r_done_count      <= '0;
            r_poll_enabled    <= 1'b0;
            r_device_code     <= i2cee_pkg::DEVICE_CODE_RST;
            r_high_block_bits <= i2cee_pkg::HIGH_BLOCK_RST;
            r_low_block_bits  <= i2cee_pkg::LOW_BLOCK_RST;
        end else begin
            if (accept) begin
                r_phase         <= n_phase;
                r_control_byte  <= n_control_byte;
                r_saved_address <= n_saved_address;
                r_target_count  <= n_target_count;
                r_done_count    <= n_done_count;
                r_poll_enabled  <= n_poll_enabled;
            end
            if (i_cfg_wr_en) begin
                case (i2cee_pkg::t_cfg_idx'(i_cfg_index))
                    i2cee_pkg::CFG_DEVICE_CODE: r_device_code     <= i_cfg_data;
                    i2cee_pkg::CFG_HIGH_BLOCK:  r_high_block_bits <= i_cfg_data;
                    i2cee_pkg::CFG_LOW_BLOCK:   r_low_block_bits  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_push = accept && (run.count != '0);
    assign o_run  = run;

endmodule

### rtl/i2cee_queue.sv
// ----------------------------------------------------------------------------
// I2C EEPROM sequencer run queue
// Short FIFO of primitive runs between the front end and the output side.
// ----------------------------------------------------------------------------
module i2cee_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  i2cee_pkg::t_run    i_run,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_not_empty,
    output i2cee_pkg::t_run    o_run
);

    localparam int PTR_W = $clog2(i2cee_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(i2cee_pkg::QUEUE_DEPTH + 1);

    i2cee_pkg::t_run     r_mem [i2cee_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;
    logic                do_push;
    logic                do_pop;

    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_not_empty;
    assign o_full      = (r_count == CNT_W'(i2cee_pkg::QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_run       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/i2cee_back.sv
// ----------------------------------------------------------------------------
// I2C EEPROM sequencer output side
// Unpacks one run at a time and presents its primitives one per transfer.
// ----------------------------------------------------------------------------
module i2cee_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_not_empty,
    input  i2cee_pkg::t_run                   i_run,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [3:0]                        o_action,
    output logic [i2cee_pkg::DATA_W-1:0]      o_byte_value,
    output logic                              o_success,
    output logic                              o_last_of_run
);

    logic                                 r_busy;
    i2cee_pkg::t_run                      r_run;
    logic [i2cee_pkg::RUN_IDX_W-1:0]      r_idx;
    logic                                 take;
    logic                                 last;
    i2cee_pkg::t_res                      cur;

    assign cur   = r_run.res[r_idx];
    assign last  = ({1'b0, r_idx} + 1'b1) == r_run.count;
    assign take  = r_busy && !i_stall;
    assign o_pop = i_q_not_empty && (!r_busy || (take && last));

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_run <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (take) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    assign o_valid       = r_busy;
    assign o_action      = cur.action;
    assign o_byte_value  = cur.byte_value;
    assign o_success     = cur.success;
    assign o_last_of_run = last;

endmodule

### rtl/i2c_eeprom_transaction_sequencer_unit.sv
// ----------------------------------------------------------------------------
// I2C EEPROM transaction sequencer
// Turns EEPROM write/read commands, host data and bus responses into I2C
// bus primitives: control byte, address, data, ack/nack, stop, done.
//
//   channel   direction   handshake                payload
//   input     in          i_valid / o_stall        opcode, address, ..., bus_read_error
//   result    out         o_valid / i_stall        action, byte_value, success, last_of_run
//   config    in          i_cfg_wr_en              i_cfg_index, i_cfg_data
//
// One input item is taken per cycle while the four-entry run queue has room.
// Each item yields zero to four primitives; the output side sends one per
// cycle while the output is not stalled.
// Reset is synchronous and returns the sequencer to idle with an empty queue.
// A stalled output keeps its primitive; the input stalls only on a full queue.
// ----------------------------------------------------------------------------
module i2c_eeprom_transaction_sequencer_unit #(
    parameter int PAGE_BYTES = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_opcode,
    input  logic [i2cee_pkg::ADDR_W-1:0]      i_address,
    input  logic                              i_block_high,
    input  logic [i2cee_pkg::LEN_W-1:0]       i_length,
    input  logic                              i_poll_after_write,
    input  logic [i2cee_pkg::DATA_W-1:0]      i_data_byte,
    input  logic                              i_bus_acked,
    input  logic [i2cee_pkg::DATA_W-1:0]      i_bus_read_byte,
    input  logic                              i_bus_read_error,
    input  logic                              i_cfg_wr_en,
    input  logic [i2cee_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [i2cee_pkg::DATA_W-1:0]      i_cfg_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [3:0]                        o_action,
    output logic [i2cee_pkg::DATA_W-1:0]      o_byte_value,
    output logic                              o_success,
    output logic                              o_last_of_run
);

    logic               q_full;
    logic               q_not_empty;
    logic               push;
    logic               pop;
    i2cee_pkg::t_run    push_run;
    i2cee_pkg::t_run    head_run;

    assign o_stall = q_full;

    i2cee_front #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .i_q_full           (q_full),
        .i_opcode           (i_opcode),
        .i_address          (i_address),
        .i_block_high       (i_block_high),
        .i_length           (i_length),
        .i_poll_after_write (i_poll_after_write),
        .i_data_byte        (i_data_byte),
        .i_bus_acked        (i_bus_acked),
        .i_bus_read_byte    (i_bus_read_byte),
        .i_bus_read_error   (i_bus_read_error),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_push             (push),
        .o_run              (push_run)
    );

    i2cee_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_run       (push_run),
        .i_pop       (pop),
        .o_full      (q_full),
        .o_not_empty (q_not_empty),
        .o_run       (head_run)
    );

    i2cee_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_run         (head_run),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_action      (o_action),
        .o_byte_value  (o_byte_value),
        .o_success     (o_success),
        .o_last_of_run (o_last_of_run)
    );

endmodule

### sim/i2c_eeprom_transaction_sequencer_unit_test.sv
// ----------------------------------------------------------------------------
// I2C EEPROM transaction sequencer testbench
// Drives write/read commands, host data and bus responses into the sequencer
// and predicts the bus primitives each transfer should produce. Directed runs
// cover page clamping, ack polling, ignored items and failures; random
// traffic mostly follows well-formed transactions across several register settings
// while both channels stall and idle at random.
// ----------------------------------------------------------------------------
module i2c_eeprom_transaction_sequencer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGE_BYTES = 128;
    localparam int SETTLE_CYCLES = 20;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_W_CTL,
        SQ_W_ADDR_HI,
        SQ_W_ADDR_LO,
        SQ_W_NEED,
        SQ_W_DATA,
        SQ_W_POLL,
        SQ_R_CTL,
        SQ_R_ADDR_HI,
        SQ_R_ADDR_LO,
        SQ_R_CTL_RD,
        SQ_R_READ
    } t_seq_phase;

    typedef struct {
        i2cee_pkg::t_opcode   op;
        logic [15:0]          address;
        logic                 block_high;
        logic [15:0]          length;
        logic                 poll;
        logic [7:0]           data_byte;
        logic                 acked;
        logic [7:0]           read_byte;
        logic                 read_error;
    } t_eeprom_req;

    typedef struct {
        i2cee_pkg::t_action   action;
        logic [7:0]           byte_value;
        logic                 success;
        logic                 last;
    } t_prim;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              o_stall;
    logic [1:0]                        i_opcode = '0;
    logic [i2cee_pkg::ADDR_W-1:0]      i_address = '0;
    logic                              i_block_high = 1'b0;
    logic [i2cee_pkg::LEN_W-1:0]       i_length = '0;
    logic                              i_poll_after_write = 1'b0;
    logic [i2cee_pkg::DATA_W-1:0]      i_data_byte = '0;
    logic                              i_bus_acked = 1'b0;
    logic [i2cee_pkg::DATA_W-1:0]      i_bus_read_byte = '0;
    logic                              i_bus_read_error = 1'b0;
    logic                              i_cfg_wr_en = 1'b0;
    logic [i2cee_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [i2cee_pkg::DATA_W-1:0]      i_cfg_data = '0;
    logic                              o_valid;
    logic                              i_stall = 1'b0;
    logic [3:0]                        o_action;
    logic [i2cee_pkg::DATA_W-1:0]      o_byte_value;
    logic                              o_success;
    logic                              o_last_of_run;

    i2c_eeprom_transaction_sequencer_unit #(
        .PAGE_BYTES(PAGE_BYTES)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_opcode(i_opcode),
        .i_address(i_address),
        .i_block_high(i_block_high),
        .i_length(i_length),
        .i_poll_after_write(i_poll_after_write),
        .i_data_byte(i_data_byte),
        .i_bus_acked(i_bus_acked),
        .i_bus_read_byte(i_bus_read_byte),
        .i_bus_read_error(i_bus_read_error),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_action(o_action),
        .o_byte_value(o_byte_value),
        .o_success(o_success),
        .o_last_of_run(o_last_of_run)
    );

    // sequencer mirror
    logic [7:0]   dev_code = i2cee_pkg::DEVICE_CODE_RST;
    logic [7:0]   high_bits = i2cee_pkg::HIGH_BLOCK_RST;
    logic [7:0]   low_bits = i2cee_pkg::LOW_BLOCK_RST;
    t_seq_phase   sq_phase = SQ_IDLE;
    logic [7:0]   sq_ctl = '0;
    logic [15:0]  sq_addr = '0;
    logic [15:0]  sq_target = '0;
    logic [15:0]  sq_done = '0;
    logic         sq_poll = 1'b0;

    t_prim        run_prims[$];
    t_prim        primitives_due[$];
    int           last_run_len = 0;
    int           mismatch_count = 0;
    bit           calm = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < 16);
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_primitives
        t_prim want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (primitives_due.size() == 0) begin
                report_mismatch($sformatf("unexpected primitive, action %0d", o_action));
            end else begin
                want = primitives_due.pop_front();
                if (o_action !== want.action)
                    report_mismatch($sformatf("action %0d, expected %0d",
                                              o_action, want.action));
                if (o_byte_value !== want.byte_value)
                    report_mismatch($sformatf("byte %02h, expected %02h (action %0d)",
                                              o_byte_value, want.byte_value, want.action));
                if (o_success !== want.success)
                    report_mismatch($sformatf("success %0b, expected %0b (action %0d)",
                                              o_success, want.success, want.action));
                if (o_last_of_run !== want.last)
                    report_mismatch($sformatf("last_of_run %0b, expected %0b (action %0d)",
                                              o_last_of_run, want.last, want.action));
            end
        end
    end

    function void put_prim(input i2cee_pkg::t_action a, input logic [7:0] v,
                           input logic ok);
        t_prim p;
        p.action = a;
        p.byte_value = v;
        p.success = ok;
        p.last = 1'b0;
        run_prims.push_back(p);
    endfunction

    function void end_transaction(input logic ok);
        put_prim(i2cee_pkg::ACT_DONE, 8'h00, ok);
        sq_phase = SQ_IDLE;
    endfunction

    function void close_write();
        put_prim(i2cee_pkg::ACT_STOP, 8'h00, 1'b0);
        if (sq_poll) begin
            put_prim(i2cee_pkg::ACT_START, 8'h00, 1'b0);
            put_prim(i2cee_pkg::ACT_WRITE, sq_ctl & i2cee_pkg::CTL_WRITE_MASK, 1'b0);
            sq_phase = SQ_W_POLL;
        end else begin
            end_transaction(1'b1);
        end
    endfunction

    function void open_transaction(input t_eeprom_req r);
        int unsigned span;
        int unsigned offset;
        sq_ctl = dev_code | (r.block_high ? high_bits : low_bits);
        sq_addr = r.address;
        sq_done = '0;
        span = 32'(r.length);
        if (r.op == i2cee_pkg::OP_READ_CMD) begin
            if (span == 0)
                span = 1;
            sq_poll = 1'b0;
            sq_phase = SQ_R_CTL;
        end else begin
            offset = sq_addr % PAGE_BYTES;
            if (span > PAGE_BYTES)
                span = PAGE_BYTES;
            if (offset + span > PAGE_BYTES)
                span = PAGE_BYTES - offset;
            sq_poll = r.poll;
            sq_phase = SQ_W_CTL;
        end
        sq_target = span[15:0];
        put_prim(i2cee_pkg::ACT_START, 8'h00, 1'b0);
        put_prim(i2cee_pkg::ACT_WRITE, sq_ctl & i2cee_pkg::CTL_WRITE_MASK, 1'b0);
    endfunction

    function void take_bus_reply(input t_eeprom_req r);
        if (sq_phase == SQ_R_READ) begin
            if (r.read_error) begin
                end_transaction(1'b0);
            end else begin
                put_prim(i2cee_pkg::ACT_TOHOST, r.read_byte, 1'b0);
                sq_done = sq_done + 16'd1;
                if (sq_done < sq_target) begin
                    put_prim(i2cee_pkg::ACT_ACK, 8'h00, 1'b0);
                    put_prim(i2cee_pkg::ACT_READ, 8'h00, 1'b0);
                end else begin
                    put_prim(i2cee_pkg::ACT_NACK, 8'h00, 1'b0);
                    put_prim(i2cee_pkg::ACT_STOP, 8'h00, 1'b0);
                    end_transaction(1'b1);
                end
            end
        end else if (sq_phase == SQ_W_POLL) begin
            if (r.acked) begin
                end_transaction(1'b1);
            end else begin
                put_prim(i2cee_pkg::ACT_START, 8'h00, 1'b0);
                put_prim(i2cee_pkg::ACT_WRITE, sq_ctl & i2cee_pkg::CTL_WRITE_MASK, 1'b0);
            end
        end else if (sq_phase != SQ_IDLE && sq_phase != SQ_W_NEED) begin
            if (!r.acked) begin
                end_transaction(1'b0);
            end else begin
                case (sq_phase)
                    SQ_W_CTL, SQ_R_CTL: begin
                        put_prim(i2cee_pkg::ACT_WRITE, sq_addr[15:8], 1'b0);
                        sq_phase = (sq_phase == SQ_W_CTL) ? SQ_W_ADDR_HI : SQ_R_ADDR_HI;
                    end
                    SQ_W_ADDR_HI, SQ_R_ADDR_HI: begin
                        put_prim(i2cee_pkg::ACT_WRITE, sq_addr[7:0], 1'b0);
                        sq_phase = (sq_phase == SQ_W_ADDR_HI) ? SQ_W_ADDR_LO : SQ_R_ADDR_LO;
                    end
                    SQ_W_ADDR_LO: begin
                        if (sq_target == 0)
                            close_write();
                        else
                            sq_phase = SQ_W_NEED;
                    end
                    SQ_W_DATA: begin
                        sq_done = sq_done + 16'd1;
                        if (sq_done >= sq_target)
                            close_write();
                        else
                            sq_phase = SQ_W_NEED;
                    end
                    SQ_R_ADDR_LO: begin
                        put_prim(i2cee_pkg::ACT_RESTART, 8'h00, 1'b0);
                        put_prim(i2cee_pkg::ACT_WRITE, sq_ctl | i2cee_pkg::CTL_READ_BIT, 1'b0);
                        sq_phase = SQ_R_CTL_RD;
                    end
                    SQ_R_CTL_RD: begin
                        put_prim(i2cee_pkg::ACT_READ, 8'h00, 1'b0);
                        sq_phase = SQ_R_READ;
                    end
                    default: begin
                    end
                endcase
            end
        end
    endfunction

    function void predict_transfer(input t_eeprom_req r);
        run_prims.delete();
        case (r.op)
            i2cee_pkg::OP_WRITE_CMD, i2cee_pkg::OP_READ_CMD: begin
                if (sq_phase == SQ_IDLE)
                    open_transaction(r);
            end
            i2cee_pkg::OP_HOST_DATA: begin
                if (sq_phase == SQ_W_NEED) begin
                    put_prim(i2cee_pkg::ACT_WRITE, r.data_byte, 1'b0);
                    sq_phase = SQ_W_DATA;
                end
            end
            default: take_bus_reply(r);
        endcase
        last_run_len = run_prims.size();
        if (last_run_len > 0)
            run_prims[last_run_len-1].last = 1'b1;
        foreach (run_prims[k])
            primitives_due.push_back(run_prims[k]);
    endfunction

    function t_eeprom_req random_req();
        t_eeprom_req r;
        r.op = i2cee_pkg::t_opcode'($urandom_range(3));
        r.address = 16'($urandom_range(65535));
        r.block_high = 1'($urandom_range(1));
        r.length = 16'($urandom_range(65535));
        r.poll = 1'($urandom_range(1));
        r.data_byte = 8'($urandom_range(255));
        r.acked = 1'($urandom_range(1));
        r.read_byte = 8'($urandom_range(255));
        r.read_error = 1'($urandom_range(1));
        return r;
    endfunction

    function logic [15:0] pick_length();
        int sel;
        sel = $urandom_range(99);
        if (sel < 80)
            return 16'($urandom_range(8));
        else if (sel < 92)
            return 16'($urandom_range(300));
        return 16'($urandom_range(65535));
    endfunction

    // follow the transaction most of the time; wind_down drives it to completion
    function t_eeprom_req next_req(input bit wind_down);
        t_eeprom_req r;
        r = random_req();
        if (!wind_down && $urandom_range(99) < 15)
            return r;
        case (sq_phase)
            SQ_IDLE: begin
                r.op = $urandom_range(1) ? i2cee_pkg::OP_READ_CMD : i2cee_pkg::OP_WRITE_CMD;
                r.length = pick_length();
            end
            SQ_W_NEED: r.op = i2cee_pkg::OP_HOST_DATA;
            SQ_W_POLL: begin
                r.op = i2cee_pkg::OP_BUS_RESP;
                r.acked = wind_down || $urandom_range(1);
            end
            SQ_R_READ: begin
                r.op = i2cee_pkg::OP_BUS_RESP;
                r.read_error = (sq_done >= 6) || (!wind_down && $urandom_range(99) < 5);
            end
            default: begin
                r.op = i2cee_pkg::OP_BUS_RESP;
                r.acked = wind_down ? (sq_phase != SQ_W_DATA) : ($urandom_range(99) >= 4);
            end
        endcase
        return r;
    endfunction

    task automatic send_item(input t_eeprom_req r);
        int gap;
        gap = (!calm && $urandom_range(99) < 16) ? 1 : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= r.op;
        i_address <= r.address;
        i_block_high <= r.block_high;
        i_length <= r.length;
        i_poll_after_write <= r.poll;
        i_data_byte <= r.data_byte;
        i_bus_acked <= r.acked;
        i_bus_read_byte <= r.read_byte;
        i_bus_read_error <= r.read_error;
        do @(posedge i_clk); while (o_stall);
        predict_transfer(r);
    endtask

    task automatic send_cmd(input i2cee_pkg::t_opcode op, input logic [15:0] addr,
                            input logic blk, input logic [15:0] len, input logic poll);
        t_eeprom_req r;
        r = random_req();
        r.op = op;
        r.address = addr;
        r.block_high = blk;
        r.length = len;
        r.poll = poll;
        send_item(r);
    endtask

    task automatic send_data(input logic [7:0] b);
        t_eeprom_req r;
        r = random_req();
        r.op = i2cee_pkg::OP_HOST_DATA;
        r.data_byte = b;
        send_item(r);
    endtask

    task automatic send_resp(input logic acked, input logic [7:0] rb, input logic rerr);
        t_eeprom_req r;
        r = random_req();
        r.op = i2cee_pkg::OP_BUS_RESP;
        r.acked = acked;
        r.read_byte = rb;
        r.read_error = rerr;
        send_item(r);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (primitives_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input i2cee_pkg::t_cfg_idx idx, input logic [7:0] v);
        i_cfg_index <= idx;
        i_cfg_data <= v;
        i_cfg_wr_en <= 1'b1;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        case (idx)
            i2cee_pkg::CFG_DEVICE_CODE: dev_code = v;
            i2cee_pkg::CFG_HIGH_BLOCK:  high_bits = v;
            i2cee_pkg::CFG_LOW_BLOCK:   low_bits = v;
            default: begin
            end
        endcase
    endtask

    task automatic write_all_regs(input logic [7:0] dc, input logic [7:0] hb,
                                  input logic [7:0] lb);
        write_reg(i2cee_pkg::CFG_DEVICE_CODE, dc);
        write_reg(i2cee_pkg::CFG_HIGH_BLOCK, hb);
        write_reg(i2cee_pkg::CFG_LOW_BLOCK, lb);
    endtask

    task automatic run_traffic(input int n);
        int served;
        served = 0;
        while (served < n) begin
            send_item(next_req(1'b0));
            served++;
        end
        while (sq_phase != SQ_IDLE)
            send_item(next_req(1'b1));
        settle();
    endtask

    // last byte of a page with an oversized length, busy and stray items, polling
    task automatic test_polled_byte_write();
        send_cmd(i2cee_pkg::OP_WRITE_CMD, 16'h007F, 1'b1, 16'hFFFF, 1'b1);
        send_resp(1'b1, 8'h00, 1'b0);
        send_resp(1'b1, 8'h00, 1'b0);
        send_cmd(i2cee_pkg::OP_READ_CMD, 16'h1234, 1'b0, 16'd3, 1'b0);
        send_resp(1'b1, 8'h00, 1'b0);
        send_resp(1'b1, 8'hFF, 1'b1);
        send_data(8'hFF);
        send_data(8'h00);
        send_resp(1'b1, 8'h00, 1'b0);
        send_resp(1'b0, 8'h00, 1'b0);
        send_resp(1'b1, 8'h00, 1'b0);
        settle();
    endtask

    // stray items while idle, then a zero-length read at the top address
    task automatic test_single_byte_read();
        send_data(8'hA5);
        send_resp(1'b1, 8'h5A, 1'b0);
        send_cmd(i2cee_pkg::OP_READ_CMD, 16'hFFFF, 1'b0, 16'd0, 1'b1);
        repeat (4) send_resp(1'b1, 8'h00, 1'b0);
        send_resp(1'b0, 8'hFF, 1'b0);
        settle();
    endtask

    // address-only write, then a write refused at the control byte
    task automatic test_short_and_refused_writes();
        send_cmd(i2cee_pkg::OP_WRITE_CMD, 16'h0000, 1'b0, 16'd0, 1'b0);
        repeat (3) send_resp(1'b1, 8'h00, 1'b0);
        send_cmd(i2cee_pkg::OP_WRITE_CMD, 16'h8000, 1'b1, 16'd5, 1'b1);
        send_resp(1'b0, 8'h00, 1'b0);
        settle();
    endtask

    task automatic test_register_extremes();
        write_all_regs(8'd0, 8'd0, 8'd0);
        run_traffic(10);
        write_all_regs(8'd254, 8'd254, 8'd254);
        run_traffic(10);
    endtask

    task automatic test_random_traffic();
        write_all_regs(8'($urandom_range(254)), 8'($urandom_range(254)),
                       8'($urandom_range(254)));
        run_traffic(20);
        calm = 1'b1;
        run_traffic(15);
        calm = 1'b0;
        write_all_regs(8'($urandom_range(254)), 8'($urandom_range(254)),
                       8'($urandom_range(254)));
        run_traffic(15);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_polled_byte_write();
        test_single_byte_read();
        test_short_and_refused_writes();
        test_register_extremes();
        test_random_traffic();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
